### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property at every clock edge outside reset
`define SWS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that an antecedent implies a consequent in the same cycle
`define SWS_CHECK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SWS_CHECK(lbl, prop, msg)
`define SWS_CHECK_IMPL(lbl, ante, cons, msg)
`endif
`endif

### design/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, types and helpers of the sliding window frequency sum.
// ----------------------------------------------------------------------------
`default_nettype none
package sws_pkg;
	localparam int WINDOW_MAX    = 64;
	localparam int VALUE_BITS    = 31;
	localparam int IDX_BITS      = $clog2(WINDOW_MAX);
	localparam int CNT_BITS      = $clog2(WINDOW_MAX + 1);
	localparam int TBL_BITS      = VALUE_BITS + CNT_BITS;
	localparam int SUM_BITS      = 37;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_X      = 2'd1;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] value;
	} item_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]      window;
		logic [CFG_DATA_BITS-1:0] top_x;
	} cfg_t;

	typedef struct packed {
		logic [WINDOW_MAX-1:0] used;
		logic [CNT_BITS-1:0]   fill;
	} back_status_t;

	// clamp the window length register into 1..WINDOW_MAX
	function automatic logic [CNT_BITS-1:0] eff_window(input logic [CFG_DATA_BITS-1:0] len);
		logic [CNT_BITS-1:0] w;
		if (len == '0) begin
			w = CNT_BITS'(1);
		end else if (int'(len) > WINDOW_MAX) begin
			w = CNT_BITS'(WINDOW_MAX);
		end else begin
			w = CNT_BITS'(len);
		end
		return w;
	endfunction
endpackage
`default_nettype wire

### design/sliding_window_top_frequency_sum.sv
// ----------------------------------------------------------------------------
// sliding_window_top_frequency_sum
// Sliding window of recent values, ranked by frequency, top ranked sum.
// ----------------------------------------------------------------------------
// Each transfer on the input side adds one value to a window of the last
// window_len values (start_of_sequence empties the window first). Once the
// window is full, every item produces one x_sum: the sum of count * value
// over the top_x most frequent distinct values, ties going to the larger
// value. Items are processed one at a time by a sequencer that walks the
// 64-entry distinct-value table one entry per cycle; each table scan ends
// in an update step. An item without a result takes the idle and check
// dispatch states and one add scan. An item with a result also takes
// k = min(top_x, distinct + 1) ranking scans (one extra scan finds that
// the distinct values ran out when top_x exceeds them, none when top_x is
// zero), plus the eviction after the output. Each value evicted because
// the window was shrunk adds one removal scan. A two-entry input queue and
// the output register let both sides stall independently.
`default_nettype none
`include "assert_macros.svh"
module sliding_window_top_frequency_sum (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sws_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [sws_pkg::VALUE_BITS-1:0]    sample_value,
	input  wire logic                              start_of_sequence,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [sws_pkg::SUM_BITS-1:0]           x_sum
);
	import sws_pkg::*;

	logic [CFG_DATA_BITS-1:0] window_len_q;
	logic [CFG_DATA_BITS-1:0] top_x_q;
	cfg_t                     cfg;
	logic                     avail;
	logic                     pop;
	item_t                    item;
	back_status_t             status;

	// configuration is always taken; unused indexes drop the write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= CFG_DATA_BITS'(1);
			top_x_q      <= CFG_DATA_BITS'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_WINDOW_LEN) begin
				window_len_q <= cfg_data;
			end else if (cfg_index == REG_TOP_X) begin
				top_x_q <= cfg_data;
			end
		end
	end

	// clamp the window length once, here, for the whole back end
	assign cfg.window = eff_window(window_len_q);
	assign cfg.top_x  = top_x_q;

	sws_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample_value      (sample_value),
		.start_of_sequence (start_of_sequence),
		.pop               (pop),
		.avail             (avail),
		.item              (item)
	);

	sws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.avail     (avail),
		.item      (item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_sum     (x_sum),
		.status    (status)
	);

	`SWS_CHECK(a_fill_bound, status.fill <= CNT_BITS'(WINDOW_MAX), "window fill beyond depth")
	`SWS_CHECK(a_distinct_le_fill, $countones(status.used) <= int'(status.fill), "more distinct than held")
	`SWS_CHECK_IMPL(a_empty_table, status.fill == '0, status.used == '0, "table not empty with empty window")
endmodule
`default_nettype wire

### design/sws_ram.sv
// ----------------------------------------------------------------------------
// sws_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### design/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// Input side: accepts items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sws_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [sws_pkg::VALUE_BITS-1:0] sample_value,
	input  wire logic                           start_of_sequence,
	input  wire logic                           pop,
	output logic                                avail,
	output sws_pkg::item_t                      item
);
	import sws_pkg::*;

	item_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_q;
	logic [QPTR_BITS-1:0]  rd_q;
	logic [QCNT_BITS-1:0]  cnt_q;
	logic                  push;

	assign in_ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
	assign avail    = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign item     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{start: start_of_sequence, value: sample_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && avail) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !(pop && avail)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop && avail) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### design/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// Back end sequencer: window ring, distinct value table, ranking scans.
// ----------------------------------------------------------------------------
`default_nettype none
module sws_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  sws_pkg::cfg_t                     cfg,
	input  wire logic                         avail,
	input  sws_pkg::item_t                    item,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [sws_pkg::SUM_BITS-1:0]      x_sum,
	output sws_pkg::back_status_t             status
);
	import sws_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CHECK   = 8'b0000_0010,
		ST_EV_RD   = 8'b0000_0100,
		ST_EV_WAIT = 8'b0000_1000,
		ST_SCAN    = 8'b0001_0000,
		ST_UPD     = 8'b0010_0000,
		ST_RANK    = 8'b0100_0000,
		ST_OUT     = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		MODE_REMOVE = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_RANK   = 2'd2
	} mode_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [IDX_BITS-1:0]     head_q;
	logic [CNT_BITS-1:0]     fill_q;
	logic [WINDOW_MAX-1:0]   used_q;
	logic [VALUE_BITS-1:0]   v_q;
	logic [VALUE_BITS-1:0]   tgt_q;
	logic                    post_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    p_s1;
	logic [IDX_BITS-1:0]     idx_s1;
	logic                    hit_q;
	logic [IDX_BITS-1:0]     hit_idx_q;
	logic [CNT_BITS-1:0]     hit_cnt_q;
	logic                    free_q;
	logic [IDX_BITS-1:0]     free_idx_q;
	logic                    best_q;
	logic [TBL_BITS-1:0]     best_key_q;
	logic                    lim_q;
	logic [TBL_BITS-1:0]     lim_key_q;
	logic [CNT_BITS-1:0]     n_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic                    out_valid_q;
	logic [SUM_BITS-1:0]     x_sum_q;

	logic                    ring_we;
	logic [IDX_BITS-1:0]     ring_waddr;
	logic                    ring_re;
	logic [VALUE_BITS-1:0]   ring_rdata;
	logic                    tbl_we;
	logic [IDX_BITS-1:0]     tbl_waddr;
	logic [TBL_BITS-1:0]     tbl_wdata;
	logic                    tbl_re;
	logic [TBL_BITS-1:0]     tbl_rdata;
	logic [VALUE_BITS-1:0]   rd_val;
	logic [CNT_BITS-1:0]     rd_cnt;
	logic [TBL_BITS-1:0]     rd_key;
	logic [CNT_BITS:0]       ring_sum;
	logic [IDX_BITS-1:0]     head_next;
	logic [TBL_BITS-1:0]     prod;

	assign rd_val = tbl_rdata[CNT_BITS +: VALUE_BITS];
	assign rd_cnt = tbl_rdata[CNT_BITS-1:0];
	// rank key: count first, value breaks a tie
	assign rd_key = {rd_cnt, rd_val};
	assign prod   = TBL_BITS'(best_key_q[VALUE_BITS +: CNT_BITS]) *
		TBL_BITS'(best_key_q[VALUE_BITS-1:0]);

	assign ring_sum   = (CNT_BITS+1)'(head_q) + (CNT_BITS+1)'(fill_q);
	assign ring_waddr = (ring_sum >= (CNT_BITS+1)'(WINDOW_MAX)) ?
		IDX_BITS'(ring_sum - (CNT_BITS+1)'(WINDOW_MAX)) : IDX_BITS'(ring_sum);
	assign head_next  = (head_q == IDX_BITS'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;

	assign pop     = (state_q == ST_IDLE) && avail;
	assign ring_re = (state_q == ST_EV_RD);
	assign ring_we = (state_q == ST_UPD) && (mode_q == MODE_ADD);
	assign tbl_re  = (state_q == ST_SCAN) && (cnt_q < CNT_BITS'(WINDOW_MAX));

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = hit_idx_q;
		tbl_wdata = {tgt_q, CNT_BITS'(hit_cnt_q - 1'b1)};
		if (state_q == ST_UPD) begin
			case (mode_q)
				MODE_REMOVE: begin
					tbl_we = hit_q;
				end
				MODE_ADD: begin
					tbl_we = 1'b1;
					if (hit_q) begin
						tbl_wdata = {tgt_q, CNT_BITS'(hit_cnt_q + 1'b1)};
					end else begin
						tbl_waddr = free_idx_q;
						tbl_wdata = {tgt_q, CNT_BITS'(1)};
					end
				end
				default: begin
					tbl_we = 1'b0;
				end
			endcase
		end
	end

	sws_ram #(.WIDTH(VALUE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (v_q),
		.re    (ring_re),
		.raddr (head_q),
		.rdata (ring_rdata)
	);

	sws_ram #(.WIDTH(TBL_BITS), .DEPTH(WINDOW_MAX)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (tbl_rdata)
	);

	// payload registers of the scan, the input value and the output sum
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_BITS-1:0];
		if (state_q == ST_IDLE && avail) begin
			v_q <= item.value;
		end
		if (state_q == ST_CHECK) begin
			tgt_q <= v_q;
		end
		if (state_q == ST_EV_WAIT) begin
			tgt_q <= ring_rdata;
		end
		if (p_s1) begin
			if (used_q[idx_s1]) begin
				if (mode_q == MODE_RANK) begin
					if ((!lim_q || rd_key < lim_key_q) && (!best_q || rd_key > best_key_q)) begin
						best_key_q <= rd_key;
					end
				end else if (rd_val == tgt_q) begin
					hit_idx_q <= idx_s1;
					hit_cnt_q <= rd_cnt;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_UPD && mode_q == MODE_RANK && best_q) begin
			lim_key_q <= best_key_q;
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			x_sum_q <= sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_REMOVE;
			head_q      <= '0;
			fill_q      <= '0;
			used_q      <= '0;
			post_q      <= 1'b0;
			cnt_q       <= '0;
			p_s1        <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			best_q      <= 1'b0;
			lim_q       <= 1'b0;
			n_q         <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			p_s1 <= tbl_re;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (p_s1 && used_q[idx_s1]) begin
				if (mode_q == MODE_RANK) begin
					if ((!lim_q || rd_key < lim_key_q) && (!best_q || rd_key > best_key_q)) begin
						best_q <= 1'b1;
					end
				end else if (rd_val == tgt_q) begin
					hit_q <= 1'b1;
				end
			end else if (p_s1 && !free_q) begin
				free_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						post_q <= 1'b0;
						if (item.start) begin
							used_q <= '0;
							head_q <= '0;
							fill_q <= '0;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (fill_q >= cfg.window) begin
						state_q <= ST_EV_RD;
					end else begin
						mode_q  <= MODE_ADD;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_EV_RD: begin
					state_q <= ST_EV_WAIT;
				end
				ST_EV_WAIT: begin
					mode_q  <= MODE_REMOVE;
					cnt_q   <= '0;
					hit_q   <= 1'b0;
					free_q  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q < CNT_BITS'(WINDOW_MAX)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					case (mode_q)
						MODE_REMOVE: begin
							if (hit_q && hit_cnt_q == CNT_BITS'(1)) begin
								used_q[hit_idx_q] <= 1'b0;
							end
							head_q  <= head_next;
							fill_q  <= fill_q - 1'b1;
							state_q <= post_q ? ST_IDLE : ST_CHECK;
						end
						MODE_ADD: begin
							if (!hit_q) begin
								used_q[free_idx_q] <= 1'b1;
							end
							fill_q  <= fill_q + 1'b1;
							state_q <= (CNT_BITS'(fill_q + 1'b1) == cfg.window) ? ST_RANK : ST_IDLE;
						end
						default: begin
							if (best_q) begin
								sum_q <= sum_q + SUM_BITS'(prod);
								n_q   <= n_q + 1'b1;
								lim_q <= 1'b1;
								if ((int'(n_q) + 1) < int'(cfg.top_x)) begin
									cnt_q   <= '0;
									best_q  <= 1'b0;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_OUT;
								end
							end else begin
								state_q <= ST_OUT;
							end
						end
					endcase
				end
				ST_RANK: begin
					sum_q  <= '0;
					n_q    <= '0;
					lim_q  <= 1'b0;
					mode_q <= MODE_RANK;
					if (cfg.top_x == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q   <= '0;
						best_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						post_q      <= 1'b1;
						state_q     <= ST_EV_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign x_sum       = x_sum_q;
	assign status.used = used_q;
	assign status.fill = fill_q;
endmodule
`default_nettype wire
